/* src/pr2n_pkg.sv */
// shared types, constants and helpers for the pitch ratio to note converter
// used by every module of the block; depends on nothing
package pr2n_pkg;

    // curve arithmetic
    localparam int unsigned CURVE_W      = 14;
    localparam int unsigned MUL_W        = 13;
    localparam int unsigned PROD_W       = CURVE_W + MUL_W;
    localparam int unsigned POS_W        = CURVE_W + 16;
    localparam int unsigned FRAC_BITS    = 12;
    localparam int unsigned SLICE_SHIFT  = 5;
    localparam logic [CURVE_W-1:0] CURVE_UNITY = 14'h1000;
    localparam logic [MUL_W-1:0]   CURVE_MUL   = 13'h103B;

    // scan bounds and index layout
    localparam logic [5:0]  LAST_SUBSTEP = 6'd47;
    localparam logic [4:0]  LAST_SLICE   = 5'd31;
    localparam int unsigned IDX_W        = 11;
    localparam logic [IDX_W-1:0] NO_MATCH_IDX = 11'h600;

    // octave term offset: twelve semitones times twelve octaves below unity
    localparam logic signed [8:0] OCT_BIAS = 9'sd144;

    typedef struct packed {
        logic [15:0] center_note;
        logic [15:0] center_fine;
        logic [15:0] pitch;
    } t_in_item;

    typedef struct packed {
        logic signed [17:0] note_out;
        logic [16:0]        fine_out;
        logic signed [31:0] packed_result;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_MUL   = 2'd0,
        ALU_SPAN  = 2'd1,
        ALU_SLICE = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [CURVE_W-1:0]  curve;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    step;
        logic [3:0]          shift;
    } t_alu_req;

    // 12 * (b - 12) as a signed value
    function automatic logic signed [8:0] octave_term(input logic [3:0] b);
        logic [8:0] times12;
        times12 = ({5'd0, b} << 3) + ({5'd0, b} << 2);
        return $signed(times12) - OCT_BIAS;
    endfunction

endpackage

/* src/pitch_ratio_to_note_core.sv */
// top level of the pitch ratio to note converter: handshake, scan sequencer
// and result register; depends on pr2n_pkg, pr2n_msb and pr2n_curve_alu

// Converts an unsigned 16.0 pitch ratio with a center note and fine value
// into a note, a fine value and the packed (note << 8) | fine word. One item
// is worked at a time: after the input transfer the sequencer walks 48 curve
// sub-steps, each made of a multiply and a span step in the shared curve unit
// and then one linear slice per cycle until the slice holding the pitch is
// found or the last sub-step ends without a match. The input stall is high
// from the input transfer until the result is moved into the output
// register; a finished result sits in the output register while the next
// input transfer is taken.
module pitch_ratio_to_note_core
    import pr2n_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_MUL   = 3'd1,
        S_SPAN  = 3'd2,
        S_SLICE = 3'd3,
        S_DONE  = 3'd4
    } t_state;

    t_state             r_state;
    logic [15:0]        r_cn;
    logic [15:0]        r_cf;
    logic [15:0]        r_p;
    logic [3:0]         r_b;
    logic [5:0]         r_sub;
    logic [4:0]         r_sl;
    logic [IDX_W-1:0]   r_idx;
    logic [CURVE_W-1:0] r_curve;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_step;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_xfer;
    logic               out_free;
    logic [3:0]         msb;
    t_alu_req           alu_req;
    logic [POS_W-1:0]   alu_res;
    logic [17:0]        p_ext;
    logic               hit;
    logic signed [17:0] n_note;
    logic [16:0]        n_fine;
    logic [31:0]        n_packed;

    // handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    pr2n_msb u_msb (
        .i_pitch (i_in_data.pitch),
        .o_msb   (msb)
    );

    // shared unit request
    always_comb begin
        alu_req.curve = r_curve;
        alu_req.pos   = r_pos;
        alu_req.step  = r_step;
        alu_req.shift = r_b;
        case (r_state)
            S_MUL:   alu_req.op = ALU_MUL;
            S_SPAN:  alu_req.op = ALU_SPAN;
            default: alu_req.op = ALU_SLICE;
        endcase
    end

    pr2n_curve_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_res)
    );

    // slice hit test against [pos, pos + step) in integer units
    assign p_ext = {2'b00, r_p};
    assign hit   = (p_ext >= r_pos[POS_W-1:FRAC_BITS]) &&
                   (p_ext <  alu_res[POS_W-1:FRAC_BITS]);

    // result formatting
    assign n_note   = 18'($signed({2'b00, r_cn})) +
                      18'($signed({14'd0, r_idx[IDX_W-1:7]})) +
                      18'(octave_term(r_b));
    assign n_fine   = {1'b0, r_cf} + {10'd0, r_idx[6:0]};
    assign n_packed = (32'(n_note) << 8) | {15'd0, n_fine};

    // sequencer, datapath and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // result taken with nothing new to present
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cn    <= i_in_data.center_note;
                        r_cf    <= i_in_data.center_fine;
                        r_p     <= i_in_data.pitch;
                        r_b     <= msb;
                        r_curve <= CURVE_UNITY;
                        r_sub   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pos   <= POS_W'(r_curve) << r_b;
                    r_curve <= alu_res[CURVE_W-1:0];
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    r_step  <= alu_res;
                    r_sl    <= '0;
                    r_state <= S_SLICE;
                end
                S_SLICE: begin
                    r_pos <= alu_res;
                    if (hit) begin
                        r_idx   <= {r_sub, r_sl};
                        r_state <= S_DONE;
                    end else if (r_sl == LAST_SLICE) begin
                        if (r_sub == LAST_SUBSTEP) begin
                            r_idx   <= NO_MATCH_IDX;
                            r_state <= S_DONE;
                        end else begin
                            r_sub   <= r_sub + 6'd1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_sl <= r_sl + 5'd1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.note_out      <= n_note;
                        r_out.fine_out      <= n_fine;
                        r_out.packed_result <= $signed(n_packed);
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_xfer_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_MUL))
        else $error("input transfer did not start the scan");

    a_sub_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLICE) |-> (r_sub <= LAST_SUBSTEP))
        else $error("sub-step counter out of range");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_idx <= NO_MATCH_IDX))
        else $error("curve index out of range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result presented outside of done state");

endmodule

/* src/pr2n_msb.sv */
// highest set bit finder for the pitch ratio
// depends on pr2n_pkg
module pr2n_msb
    import pr2n_pkg::*;
(
    input  logic [15:0] i_pitch,
    output logic [3:0]  o_msb
);

    // priority encode, zero when no bit above bit 0 is set
    always_comb begin
        o_msb = 4'd0;
        for (int s = 0; s < 16; s++) begin
            if (i_pitch[s]) begin
                o_msb = 4'(s);
            end
        end
    end

endmodule

/* src/pr2n_curve_alu.sv */
// shared curve arithmetic unit: curve multiply, slice span and slice advance
// depends on pr2n_pkg
module pr2n_curve_alu
    import pr2n_pkg::*;
(
    input  t_alu_req         i_req,
    output logic [POS_W-1:0] o_result
);

    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  top;
    logic [POS_W-1:0]  span;

    // next curve point product
    assign prod = PROD_W'(i_req.curve) * PROD_W'(CURVE_MUL);

    // span of one sub-step from its base to the scaled next curve point
    assign top  = POS_W'(i_req.curve) << i_req.shift;
    assign span = top - i_req.pos;

    // operation select
    always_comb begin
        case (i_req.op)
            ALU_MUL:   o_result = POS_W'(prod >> FRAC_BITS);
            ALU_SPAN:  o_result = span >> SLICE_SHIFT;
            ALU_SLICE: o_result = i_req.pos + i_req.step;
            default:   o_result = '0;
        endcase
    end

endmodule
